// ===== sv/cle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

    localparam int LINE_BYTES = 128;
    localparam int CAPACITY   = LINE_BYTES - 3;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int CMP_W      = (ADDR_W > 7) ? ADDR_W : 7;
    localparam int BYTE_W     = 7;
    localparam int ECHO_MAX   = 6;
    localparam int CNT_W      = 3;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [BYTE_W-1:0] K_BELL   = 7'h07;
    localparam logic [BYTE_W-1:0] K_BS     = 7'h08;
    localparam logic [BYTE_W-1:0] K_TAB    = 7'h09;
    localparam logic [BYTE_W-1:0] K_LF     = 7'h0a;
    localparam logic [BYTE_W-1:0] K_FF     = 7'h0c;
    localparam logic [BYTE_W-1:0] K_CR     = 7'h0d;
    localparam logic [BYTE_W-1:0] K_KILL   = 7'h15;
    localparam logic [BYTE_W-1:0] K_QUOTE  = 7'h16;
    localparam logic [BYTE_W-1:0] K_DEL    = 7'h7f;
    localparam logic [BYTE_W-1:0] K_SPACE  = 7'h20;
    localparam logic [BYTE_W-1:0] K_TILDE  = 7'h7e;
    localparam logic [BYTE_W-1:0] K_ZERO   = 7'h30;
    localparam logic [BYTE_W-1:0] K_BSLASH = 7'h5c;
    localparam logic [BYTE_W-1:0] K_CARET  = 7'h5e;
    localparam logic [BYTE_W-1:0] K_UPPERU = 7'h55;
    localparam logic [BYTE_W-1:0] K_QMARK  = 7'h3f;
    localparam logic [BYTE_W-1:0] K_LOWB   = 7'h62;
    localparam logic [BYTE_W-1:0] K_LOWF   = 7'h66;
    localparam logic [BYTE_W-1:0] K_LOWN   = 7'h6e;
    localparam logic [BYTE_W-1:0] K_LOWR   = 7'h72;
    localparam logic [BYTE_W-1:0] K_LOWT   = 7'h74;

    typedef struct packed {
        logic [ECHO_MAX-1:0][BYTE_W-1:0] echo;
        logic [CNT_W-1:0]                cnt;
        logic                            echo_valid;
        logic                            rd_hit;
        logic                            done;
        logic [BYTE_W-1:0]               length;
    } cle_desc_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } cle_ram_req_t;

endpackage

`default_nettype wire

// ===== sv/cle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/cle_edit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cle_edit
    import cle_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [0:0]          s_tuser,
    output logic                     desc_valid,
    input  wire logic                desc_ready,
    output cle_desc_t                desc,
    output cle_ram_req_t             ram_req
);

    logic [ADDR_W-1:0] fill_reg, fill_next, fill0;
    logic              quote_reg, quote_next;
    logic              complete_reg, complete_next;
    logic              valid_reg;
    cle_desc_t         desc_reg, desc_next;

    logic              cmd;
    logic [BYTE_W-1:0] c, ch;
    logic [6:0]        idx;
    logic [CMP_W-1:0]  idx_ext, fill_ext, len_ext;
    logic              we_c, re_c, accept, room;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !valid_reg || desc_ready;
    assign cmd      = s_tuser[0];
    assign c        = s_tdata[6:0];
    assign idx      = s_tdata[14:8];
    assign idx_ext  = CMP_W'(idx);
    assign fill_ext = CMP_W'(fill_reg);
    assign fill0    = complete_reg ? '0 : fill_reg;
    assign room     = fill0 < ADDR_W'(CAPACITY);
    assign ch       = (c == K_TAB) ? K_SPACE : c;

    always_comb begin
        fill_next     = fill_reg;
        quote_next    = quote_reg;
        complete_next = complete_reg;
        desc_next     = '0;
        desc_next.cnt = CNT_W'(1);
        we_c          = 1'b0;
        re_c          = 1'b0;
        if (cmd == CMD_READ) begin
            re_c             = 1'b1;
            desc_next.rd_hit = idx_ext < fill_ext;
        end else begin
            fill_next     = fill0;
            complete_next = 1'b0;
            if (quote_reg) begin
                quote_next           = 1'b0;
                desc_next.echo_valid = 1'b1;
                if (room) begin
                    we_c      = 1'b1;
                    fill_next = fill0 + ADDR_W'(1);
                    if (c >= K_SPACE && c <= K_TILDE) begin
                        desc_next.echo[0] = c;
                    end else begin
                        desc_next.echo[0] = K_BSLASH;
                        desc_next.cnt     = CNT_W'(2);
                        case (c)
                            K_BS:    desc_next.echo[1] = K_LOWB;
                            K_FF:    desc_next.echo[1] = K_LOWF;
                            K_LF:    desc_next.echo[1] = K_LOWN;
                            K_CR:    desc_next.echo[1] = K_LOWR;
                            K_TAB:   desc_next.echo[1] = K_LOWT;
                            default: begin
                                desc_next.cnt     = CNT_W'(4);
                                desc_next.echo[1] = K_ZERO | {6'b0, c[6]};
                                desc_next.echo[2] = K_ZERO | {4'b0, c[5:3]};
                                desc_next.echo[3] = K_ZERO | {4'b0, c[2:0]};
                            end
                        endcase
                    end
                end else begin
                    desc_next.echo[0] = K_BELL;
                end
            end else if (c == K_QUOTE) begin
                quote_next = 1'b1;
            end else if (c == K_CR || c == K_LF) begin
                desc_next.echo_valid = 1'b1;
                desc_next.cnt        = CNT_W'(2);
                desc_next.echo[0]    = K_CR;
                desc_next.echo[1]    = K_LF;
                desc_next.done       = 1'b1;
                complete_next        = 1'b1;
            end else if (c == K_BS || c == K_DEL) begin
                if (fill0 != '0) begin
                    fill_next            = fill0 - ADDR_W'(1);
                    desc_next.echo_valid = 1'b1;
                    desc_next.cnt        = CNT_W'(3);
                    desc_next.echo[0]    = K_BS;
                    desc_next.echo[1]    = K_SPACE;
                    desc_next.echo[2]    = K_BS;
                end
            end else if (c == K_KILL) begin
                if (fill0 != '0) begin
                    fill_next            = '0;
                    desc_next.echo_valid = 1'b1;
                    desc_next.cnt        = CNT_W'(6);
                    desc_next.echo[0]    = K_CARET;
                    desc_next.echo[1]    = K_UPPERU;
                    desc_next.echo[2]    = K_CR;
                    desc_next.echo[3]    = K_LF;
                    desc_next.echo[4]    = K_QMARK;
                    desc_next.echo[5]    = K_SPACE;
                end
            end else begin
                desc_next.echo_valid = 1'b1;
                if (ch >= K_SPACE && ch <= K_TILDE && room) begin
                    we_c              = 1'b1;
                    fill_next         = fill0 + ADDR_W'(1);
                    desc_next.echo[0] = ch;
                end else begin
                    desc_next.echo[0] = K_BELL;
                end
            end
        end
        len_ext          = CMP_W'(fill_next);
        desc_next.length = len_ext[BYTE_W-1:0];
    end

    always_comb begin
        ram_req.we    = accept && we_c;
        ram_req.waddr = fill0;
        ram_req.wdata = quote_reg ? c : ch;
        ram_req.re    = accept && re_c;
        ram_req.raddr = idx_ext[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            quote_reg    <= 1'b0;
            complete_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg     <= fill_next;
                quote_reg    <= quote_next;
                complete_reg <= complete_next;
                valid_reg    <= 1'b1;
            end else if (desc_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            desc_reg <= desc_next;
        end
    end

    assign desc_valid = valid_reg;
    assign desc       = desc_reg;

`ifndef NO_ASSERTIONS
    a_fill_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= ADDR_W'(CAPACITY))
        else $error("line fill beyond capacity");

    a_read_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_READ) |=> ($stable(fill_reg) && $stable(quote_reg)
            && $stable(complete_reg)))
        else $error("read command altered editor state");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> (ram_req.waddr < ADDR_W'(CAPACITY)))
        else $error("store write beyond capacity");
`endif

endmodule

`default_nettype wire

// ===== sv/cle_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cle_emit
    import cle_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                desc_valid,
    output logic                     desc_ready,
    input  wire cle_desc_t           desc,
    input  wire logic [BYTE_W-1:0]   rd_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic [0:0]               m_tuser,
    output logic                     m_tlast
);

    logic              busy_reg;
    logic [CNT_W-1:0]  idx_reg;
    cle_desc_t         buf_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              last, load;

    assign last       = idx_reg == (buf_reg.cnt - CNT_W'(1));
    assign desc_ready = !busy_reg || (m_tready && last);
    assign load       = desc_valid && desc_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (busy_reg && m_tready) begin
                if (last) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg   <= desc;
            rdata_reg <= rd_data;
        end
    end

    assign m_tvalid   = busy_reg;
    assign m_tlast    = last;
    assign m_tuser[0] = buf_reg.echo_valid;
    assign m_tdata    = {2'b00, buf_reg.length, buf_reg.done, rdata_reg,
                         buf_reg.echo[idx_reg]};

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg < buf_reg.cnt && buf_reg.cnt <= CNT_W'(ECHO_MAX)))
        else $error("echo index past word count");

    a_single_when_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !buf_reg.echo_valid) |-> (buf_reg.cnt == CNT_W'(1)))
        else $error("silent result with several words");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_tready && !last && !load) |=> (busy_reg
            && idx_reg == $past(idx_reg) + CNT_W'(1)))
        else $error("echo index did not advance");
`endif

endmodule

`default_nettype wire

// ===== sv/console_line_editor.sv =====
// Console line editor.
// Input words (s_): s_tuser[0] is the command (0 = key byte, 1 = read of a
// stored byte); s_tdata carries the key byte and the read index. Each key
// edits a 128-entry line store held in a synchronous RAM.
// Result words (m_): one to six per input word. m_tuser[0] flags a valid echo
// byte; m_tdata carries echo byte, read data, line-done flag and line length;
// m_tlast marks the final word of an input.
// The first result word passes the edit stage register and then the emit
// buffer register. An input with n result words holds the output until all n
// are taken, so the output port sets the sustained input rate; the edit stage
// and RAM take a new input word every cycle while s_tready is high.
// A stalled receiver holds the current word; one decoded input waits in the
// edit stage register, after which s_tready drops.
// Reset (aresetn low, synchronous) empties the line, clears any pending quote
// and drops all queued results; the store itself needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module console_line_editor
    import cle_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // key_byte[7:0], read_index[14:8]
    input  wire logic [0:0]          s_tuser,   // command[0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // echo_byte[6:0], read_data[13:7],
                                                // line_done[14], line_length[21:15]
    output logic [0:0]               m_tuser,   // echo_valid[0]
    output logic                     m_tlast
);

    cle_desc_t         desc;
    cle_ram_req_t      ram_req;
    logic              desc_valid, desc_ready;
    logic [BYTE_W-1:0] ram_q, rd_data;

    cle_edit u_edit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .ram_req    (ram_req)
    );

    cle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_q)
    );

    // past the line length a read gives zero
    assign rd_data = desc.rd_hit ? ram_q : '0;

    cle_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .rd_data    (rd_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== test/cle_line_checker.sv =====
`timescale 1ns / 1ps

module cle_line_checker
    import cle_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key_byte[7:0], read_index[14:8]
    input  logic [0:0]          s_tuser,   // command[0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // echo_byte[6:0], read_data[13:7],
                                           // line_done[14], line_length[21:15]
    input  logic [0:0]          m_tuser,   // echo_valid[0]
    input  logic                m_tlast,
    output int                  mismatches,
    output int                  outstanding,
    output int                  stored_reach
);

    typedef struct packed {
        logic              echo_valid;
        logic [BYTE_W-1:0] echo_byte;
        logic [BYTE_W-1:0] read_data;
        logic              line_done;
        logic [BYTE_W-1:0] line_length;
        logic              last;
    } echo_word_t;

    logic [BYTE_W-1:0] line_mem [LINE_BYTES];
    int                fill;
    int                reach_seen;
    logic              quoting;
    logic              line_closed;
    echo_word_t        echo_due [$];

    // Applies one input word to the line and queues the words it should produce.
    task automatic edit_line(input logic cmd, input logic [7:0] key, input logic [6:0] idx);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] rd;
        logic [BYTE_W-1:0] len;
        logic              done;
        logic [BYTE_W-1:0] echoes [$];
        echo_word_t        w;
        int                n;
        c    = key[6:0];
        rd   = '0;
        done = 1'b0;
        if (cmd == CMD_READ) begin
            if (idx < fill) rd = line_mem[idx];
        end else begin
            if (line_closed) begin
                line_closed = 1'b0;
                fill = 0;
            end
            if (quoting) begin
                quoting = 1'b0;
                if (fill < CAPACITY) begin
                    line_mem[ADDR_W'(fill)] = c;
                    fill++;
                    if (c >= K_SPACE && c <= K_TILDE) begin
                        echoes.push_back(c);
                    end else begin
                        echoes.push_back(K_BSLASH);
                        case (c)
                            K_BS:  echoes.push_back(K_LOWB);
                            K_FF:  echoes.push_back(K_LOWF);
                            K_LF:  echoes.push_back(K_LOWN);
                            K_CR:  echoes.push_back(K_LOWR);
                            K_TAB: echoes.push_back(K_LOWT);
                            default: begin
                                echoes.push_back(K_ZERO + {6'b0, c[6]});
                                echoes.push_back(K_ZERO + {4'b0, c[5:3]});
                                echoes.push_back(K_ZERO + {4'b0, c[2:0]});
                            end
                        endcase
                    end
                end else begin
                    echoes.push_back(K_BELL);
                end
            end else if (c == K_QUOTE) begin
                quoting = 1'b1;
            end else if (c == K_CR || c == K_LF) begin
                echoes.push_back(K_CR);
                echoes.push_back(K_LF);
                done = 1'b1;
                line_closed = 1'b1;
            end else if (c == K_BS || c == K_DEL) begin
                if (fill > 0) begin
                    fill--;
                    echoes.push_back(K_BS);
                    echoes.push_back(K_SPACE);
                    echoes.push_back(K_BS);
                end
            end else if (c == K_KILL) begin
                if (fill > 0) begin
                    echoes.push_back(K_CARET);
                    echoes.push_back(K_UPPERU);
                    echoes.push_back(K_CR);
                    echoes.push_back(K_LF);
                    echoes.push_back(K_QMARK);
                    echoes.push_back(K_SPACE);
                    fill = 0;
                end
            end else begin
                if (c == K_TAB) c = K_SPACE;
                if (c >= K_SPACE && c <= K_TILDE && fill < CAPACITY) begin
                    line_mem[ADDR_W'(fill)] = c;
                    fill++;
                    echoes.push_back(c);
                end else begin
                    echoes.push_back(K_BELL);
                end
            end
        end
        if (fill > reach_seen) reach_seen = fill;
        len = BYTE_W'(fill);
        n = (echoes.size() > 0) ? echoes.size() : 1;
        for (int k = 0; k < n; k++) begin
            w.echo_valid  = echoes.size() > 0;
            w.echo_byte   = (echoes.size() > 0) ? echoes[k] : '0;
            w.read_data   = rd;
            w.line_done   = done;
            w.line_length = len;
            w.last        = (k == n - 1);
            echo_due.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        echo_word_t got;
        echo_word_t want;
        if (!aresetn) begin
            fill        = 0;
            reach_seen  = 0;
            quoting     = 1'b0;
            line_closed = 1'b0;
            echo_due.delete();
            outstanding  <= 0;
            stored_reach <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.echo_valid  = m_tuser[0];
                got.echo_byte   = m_tdata[6:0];
                got.read_data   = m_tdata[13:7];
                got.line_done   = m_tdata[14];
                got.line_length = m_tdata[21:15];
                got.last        = m_tlast;
                if (echo_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: unexpected word ",
                                  "ev=%0b echo=%02h rd=%02h done=%0b len=%0d last=%0b"},
                                 $realtime, got.echo_valid, got.echo_byte, got.read_data,
                                 got.line_done, got.line_length, got.last);
                end else begin
                    want = echo_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: word mismatch", $realtime);
                            $display({"  expected ",
                                      "ev=%0b echo=%02h rd=%02h done=%0b len=%0d last=%0b"},
                                     want.echo_valid, want.echo_byte, want.read_data,
                                     want.line_done, want.line_length, want.last);
                            $display({"  actual   ",
                                      "ev=%0b echo=%02h rd=%02h done=%0b len=%0d last=%0b"},
                                     got.echo_valid, got.echo_byte, got.read_data,
                                     got.line_done, got.line_length, got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) edit_line(s_tuser[0], s_tdata[7:0], s_tdata[14:8]);
            outstanding  <= echo_due.size();
            stored_reach <= reach_seen;
        end
    end

endmodule

// ===== test/tb_console_line_editor.sv =====
`timescale 1ns / 1ps

module tb_console_line_editor;
    import cle_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // key_byte[7:0], read_index[14:8]
    logic [0:0]          s_tuser;   // command[0]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // echo_byte[6:0], read_data[13:7],
                                    // line_done[14], line_length[21:15]
    logic [0:0]          m_tuser;   // echo_valid[0]
    logic                m_tlast;

    int mismatches;
    int outstanding;
    int stored_reach;
    int sent = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    always #10 aclk = ~aclk;

    console_line_editor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    cle_line_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .stored_reach (stored_reach)
    );

    // receiver: random stall bursts, calm runs, one long hold-off on request
    initial begin
        int stall_left;
        int calm_left;
        int hold_left;
        int r;
        bit hold_taken;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (quiet || calm_left > 0) begin
                if (calm_left > 0) calm_left--;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 2) begin
                    stall_left = $urandom_range(1, 12) - 1;
                    m_tready <= 1'b0;
                end else begin
                    if (r < 4) calm_left = $urandom_range(10, 60);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [7:0] high_bit_noise(input logic [6:0] c);
        logic [7:0] k;
        k    = {1'b0, c};
        k[7] = 1'($urandom_range(0, 1));
        return k;
    endfunction

    task automatic send_word(input logic cmd, input logic [7:0] key, input logic [6:0] idx);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, idx, key};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_key(input logic [7:0] key);
        send_word(CMD_KEY, key, 7'($urandom_range(0, 127)));
    endtask

    // reads stay within entries already written at least once (entry 0 while none is)
    task automatic send_read();
        send_word(CMD_READ, 8'($urandom_range(0, 255)),
                  (stored_reach > 0) ? 7'($urandom_range(0, stored_reach - 1)) : 7'd0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic random_line();
        int n;
        int r;
        logic [6:0] c;
        n = $urandom_range(1, 14);
        repeat (n) begin
            r = $urandom_range(0, 99);
            c = 7'($urandom_range(0, 127));
            if (r < 50) begin
                send_key(high_bit_noise(7'($urandom_range(K_SPACE, K_TILDE))));
            end else if (r < 56) begin
                send_key(high_bit_noise(K_TAB));
            end else if (r < 64) begin
                send_key(high_bit_noise(r[0] ? K_BS : K_DEL));
            end else if (r < 72) begin
                send_key(high_bit_noise(K_QUOTE));
                send_key(high_bit_noise(c));
            end else if (r < 82) begin
                send_read();
            end else if (r < 86) begin
                send_key(high_bit_noise(K_KILL));
            end else if (r < 90) begin
                send_key(high_bit_noise(r[0] ? K_CR : K_LF));
            end else begin
                send_key(high_bit_noise(c));
            end
        end
        r = $urandom_range(0, 9);
        if (r < 8) send_key(high_bit_noise(r[0] ? K_CR : K_LF));
        else if (r < 9) send_key(high_bit_noise(K_KILL));
    endtask

    initial begin
        int line_no;
        int guard;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_KEY;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: edits on an empty line, extremes, quoting, kill, completion
        send_key({1'b0, K_BS});
        send_key({1'b0, K_KILL});
        send_key(8'h41);
        send_key({1'b0, K_SPACE});
        send_key({1'b0, K_TILDE});
        send_key({1'b0, K_TAB});
        send_key(8'hc1);
        send_key(8'h00);
        send_key({1'b0, K_DEL});
        send_word(CMD_READ, 8'h00, 7'd0);
        send_word(CMD_READ, 8'hff, 7'd4);
        send_key({1'b0, K_QUOTE});
        send_word(CMD_READ, 8'h00, 7'd3);
        send_key({1'b1, K_CR});
        send_key({1'b0, K_QUOTE});
        send_key(8'h01);
        send_key({1'b0, K_QUOTE});
        send_key({1'b0, K_QUOTE});
        send_key({1'b0, K_KILL});
        send_key(8'h48);
        send_key({1'b0, K_CR});
        send_word(CMD_READ, 8'h00, 7'd0);
        send_key({1'b0, K_LF});
        send_key(8'hff);

        // fill the line to capacity and beyond
        repeat (CAPACITY + 1) send_key(high_bit_noise(7'($urandom_range(K_SPACE, K_TILDE))));
        send_key(high_bit_noise(K_QUOTE));
        send_key(high_bit_noise(7'($urandom_range(0, 127))));
        send_word(CMD_READ, 8'($urandom_range(0, 255)), 7'(CAPACITY - 1));
        send_word(CMD_READ, 8'($urandom_range(0, 255)), 7'd64);
        send_read();
        send_key(high_bit_noise(K_DEL));
        send_word(CMD_READ, 8'($urandom_range(0, 255)), 7'(CAPACITY - 1));
        send_key(high_bit_noise(K_QUOTE));
        send_key(high_bit_noise(7'($urandom_range(0, 127))));
        send_key(high_bit_noise(K_CR));

        line_no = 0;
        while (sent < 370) begin
            if (sent >= 330) quiet = 1'b1;
            if (line_no == 3) begin
                hold_req = 1'b1;
                repeat (12) send_key(high_bit_noise(7'($urandom_range(K_SPACE, K_TILDE))));
            end
            if (line_no == 8) wait_drained();
            random_line();
            line_no++;
        end

        s_tvalid <= 1'b0;
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (outstanding != 0 && guard < 20000);
        repeat (12) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cle_pkg.sv
sv/cle_ram.sv
sv/cle_edit.sv
sv/cle_emit.sv
sv/console_line_editor.sv
test/cle_line_checker.sv
test/tb_console_line_editor.sv
